>>> design/cc2d_pkg.sv
// Shared types and constants for the circular 2D convolution unit.
// No dependencies; imported by cc2d_mac, cc2d_seq and the top unit.
`timescale 1ns / 1ps

package cc2d_pkg;

  // Item field widths
  localparam int unsigned IDX_W     = 6;   // row / col field
  localparam int unsigned VAL_W     = 32;  // Q16.16 value
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned CFG_W     = 7;   // config register width
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IN_DATA_W = 48;  // row, col, value packed, byte padded

  // Datapath widths: exact Q32.32 products, at most 127 x 127 terms summed
  localparam int unsigned PROD_W = 64;
  localparam int unsigned ACC_W  = 80;
  localparam int unsigned RND_W  = ACC_W - 16;

  localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(32'sd32768);
  localparam logic [VAL_W-1:0]        S32_MAX  = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0]        S32_MIN  = 32'h8000_0000;

  typedef enum logic [KIND_W-1:0] {
    KIND_KERNEL = 2'd0,
    KIND_GRID   = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS   = 2'd0,
    REG_GRID_COLS   = 2'd1,
    REG_KERNEL_ROWS = 2'd2,
    REG_KERNEL_COLS = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRAP,
    ST_WALK,
    ST_DRAIN,
    ST_ROUND,
    ST_SAT
  } seq_state_e;

  // Sequencer -> datapath
  typedef struct packed {
    logic clr;    // clear accumulator
    logic issue;  // store reads issued this cycle
    logic round;  // round the finished sum
    logic load;   // saturate into the output register
  } mac_ctrl_t;

  // Datapath -> sequencer
  typedef struct packed {
    logic busy;      // reads or products still in flight
    logic out_free;  // output register can take a result
  } mac_stat_t;

endpackage

>>> design/cc2d_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module cc2d_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> design/cc2d_mac.sv
// Shared multiply-accumulate datapath with rounding, saturation and output register.
// Depends on cc2d_pkg.
`timescale 1ns / 1ps

module cc2d_mac (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cc2d_pkg::mac_ctrl_t           ctrl_i,
  output cc2d_pkg::mac_stat_t           stat_o,
  input  logic [cc2d_pkg::VAL_W-1:0]    kernel_i,
  input  logic [cc2d_pkg::VAL_W-1:0]    grid_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cc2d_pkg::VAL_W-1:0]    out_sum_o,
  output logic                          out_sat_o
);
  import cc2d_pkg::*;

  logic                    rd_v_q, prod_v_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [RND_W-1:0]  rnd_q;
  logic [RND_W-32:0]        rnd_hi;
  logic                     sat;
  logic [VAL_W-1:0]         sum_sat;
  logic                     out_valid_q;

  // read data valid flag registered from issue, product valid flag registered from that
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q   <= 1'b0;
      prod_v_q <= 1'b0;
    end else begin
      rd_v_q   <= ctrl_i.issue;
      prod_v_q <= rd_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= signed'(kernel_i) * signed'(grid_i);
  end

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (prod_v_q) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // half up rounding to Q16.16: add 2^15, floor
  assign acc_rnd = acc_q + RND_BIAS;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.round) begin
      rnd_q <= acc_rnd[ACC_W-1:16];
    end
  end

  // in range only if the top bits are all sign copies
  assign rnd_hi  = rnd_q[RND_W-1:31];
  assign sat     = !((&rnd_hi) || (~|rnd_hi));
  assign sum_sat = sat ? (rnd_q[RND_W-1] ? S32_MIN : S32_MAX) : rnd_q[VAL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      out_sum_o <= sum_sat;
      out_sat_o <= sat;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.busy     = rd_v_q || prod_v_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

endmodule

>>> design/cc2d_seq.sv
// Sequencer: takes items, writes the stores, wraps query indices and walks the kernel.
// Depends on cc2d_pkg.
`timescale 1ns / 1ps

module cc2d_seq #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64,
  localparam int unsigned RW  = $clog2(MAX_ROWS),
  localparam int unsigned CW  = $clog2(MAX_COLS),
  localparam int unsigned SRW = $clog2(MAX_ROWS + 1),
  localparam int unsigned SCW = $clog2(MAX_COLS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [cc2d_pkg::KIND_W-1:0]   kind_i,
  input  logic [cc2d_pkg::IDX_W-1:0]    row_i,
  input  logic [cc2d_pkg::IDX_W-1:0]    col_i,
  input  logic [SRW-1:0]                grid_rows_i,
  input  logic [SCW-1:0]                grid_cols_i,
  input  logic [SRW-1:0]                kernel_rows_i,
  input  logic [SCW-1:0]                kernel_cols_i,
  output logic                          kernel_we_o,
  output logic                          grid_we_o,
  output logic [RW+CW-1:0]              waddr_o,
  output logic [RW+CW-1:0]              kernel_raddr_o,
  output logic [RW+CW-1:0]              grid_raddr_o,
  output cc2d_pkg::mac_ctrl_t           ctrl_o,
  input  cc2d_pkg::mac_stat_t           stat_i
);
  import cc2d_pkg::*;

  localparam int unsigned ERW = (SRW > IDX_W) ? SRW : IDX_W;
  localparam int unsigned ECW = (SCW > IDX_W) ? SCW : IDX_W;

  seq_state_e       state_q, state_d;
  logic [IDX_W-1:0] rm_q, rm_d, cm_q, cm_d;
  logic [RW-1:0]    a_q, a_d, gr_q, gr_d;
  logic [CW-1:0]    b_q, b_d, gc_q, gc_d, gc0_q, gc0_d;

  logic [SRW-1:0] kr;
  logic [SCW-1:0] kc;
  logic           r_big, c_big, a_last, b_last, in_range;
  logic           accept;

  // kernel clipped to the grid
  assign kr = (kernel_rows_i < grid_rows_i) ? kernel_rows_i : grid_rows_i;
  assign kc = (kernel_cols_i < grid_cols_i) ? kernel_cols_i : grid_cols_i;

  assign r_big  = ERW'(rm_q) >= ERW'(grid_rows_i);
  assign c_big  = ECW'(cm_q) >= ECW'(grid_cols_i);
  assign a_last = SRW'(a_q) == (kr - SRW'(1));
  assign b_last = SCW'(b_q) == (kc - SCW'(1));

  assign in_range = (int'(row_i) < MAX_ROWS) && (int'(col_i) < MAX_COLS);
  assign accept   = in_valid_i && in_ready_o;

  assign waddr_o        = {RW'(row_i), CW'(col_i)};
  assign kernel_raddr_o = {a_q, b_q};
  assign grid_raddr_o   = {gr_q, gc_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rm_q  <= rm_d;
    cm_q  <= cm_d;
    a_q   <= a_d;
    b_q   <= b_d;
    gr_q  <= gr_d;
    gc_q  <= gc_d;
    gc0_q <= gc0_d;
  end

  always_comb begin
    state_d     = state_q;
    rm_d        = rm_q;
    cm_d        = cm_q;
    a_d         = a_q;
    b_d         = b_q;
    gr_d        = gr_q;
    gc_d        = gc_q;
    gc0_d       = gc0_q;
    in_ready_o  = 1'b0;
    kernel_we_o = 1'b0;
    grid_we_o   = 1'b0;
    ctrl_o      = '0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          unique case (kind_i)
            KIND_KERNEL: kernel_we_o = in_range;
            KIND_GRID:   grid_we_o   = in_range;
            KIND_QUERY: begin
              rm_d       = row_i;
              cm_d       = col_i;
              ctrl_o.clr = 1'b1;
              state_d    = ST_WRAP;
            end
            default: ;
          endcase
        end
      end

      // reduce row and col modulo the grid size, one subtraction a cycle
      ST_WRAP: begin
        if (r_big) begin
          rm_d = rm_q - IDX_W'(grid_rows_i);
        end
        if (c_big) begin
          cm_d = cm_q - IDX_W'(grid_cols_i);
        end
        if (!r_big && !c_big) begin
          a_d     = '0;
          b_d     = '0;
          gr_d    = (rm_q == '0) ? RW'(grid_rows_i - SRW'(1)) : RW'(rm_q - IDX_W'(1));
          gc_d    = (cm_q == '0) ? CW'(grid_cols_i - SCW'(1)) : CW'(cm_q - IDX_W'(1));
          gc0_d   = gc_d;
          state_d = ST_WALK;
        end
      end

      // one kernel weight and one grid cell read per cycle
      ST_WALK: begin
        ctrl_o.issue = 1'b1;
        if (b_last) begin
          b_d  = '0;
          gc_d = gc0_q;
          a_d  = a_q + RW'(1);
          gr_d = (gr_q == '0) ? RW'(grid_rows_i - SRW'(1)) : gr_q - RW'(1);
          if (a_last) begin
            state_d = ST_DRAIN;
          end
        end else begin
          b_d  = b_q + CW'(1);
          gc_d = (gc_q == '0) ? CW'(grid_cols_i - SCW'(1)) : gc_q - CW'(1);
        end
      end

      ST_DRAIN: begin
        if (!stat_i.busy) begin
          state_d = ST_ROUND;
        end
      end

      ST_ROUND: begin
        ctrl_o.round = 1'b1;
        state_d      = ST_SAT;
      end

      ST_SAT: begin
        if (stat_i.out_free) begin
          ctrl_o.load = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

endmodule

>>> design/circular_convolution_2d_unit.sv
// Circular 2D convolution unit, Q16.16: writes kernel/grid cells, answers queries.
// Operation: writes go straight to the stores. A query wraps its row and col modulo the
//   grid size, then feeds the kr*kc terms (kr, kc: kernel size clipped to the grid) to
//   the single shared multiply-accumulate, one term per cycle, then rounds and saturates.
// Throughput: one query at a time, up to 4096 terms at default sizes; writes each idle cycle.
// Reset: size registers to 64 (clamped to MAX_ROWS / MAX_COLS); stores uninitialised.
// Depends on cc2d_pkg, cc2d_ram, cc2d_mac, cc2d_seq.
`timescale 1ns / 1ps

module circular_convolution_2d_unit #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [cc2d_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cc2d_pkg::CFG_W-1:0]        cfg_wdata_i,
  // input items
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [cc2d_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // row[5:0], col[11:6], value[43:12]
  input  logic [cc2d_pkg::KIND_W-1:0]       s_axis_tuser,  // kind[1:0]
  // result items
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [cc2d_pkg::VAL_W-1:0]        m_axis_tdata,  // sum[31:0]
  output logic                              m_axis_tuser   // saturated[0]
);
  import cc2d_pkg::*;

  localparam int unsigned RW    = $clog2(MAX_ROWS);
  localparam int unsigned CW    = $clog2(MAX_COLS);
  localparam int unsigned SRW   = $clog2(MAX_ROWS + 1);
  localparam int unsigned SCW   = $clog2(MAX_COLS + 1);
  localparam int unsigned DEPTH = 2 ** (RW + CW);

  // reset sizes: 64, clamped to the store size
  localparam logic [SRW-1:0] ROWS_RST = (MAX_ROWS < 64) ? SRW'(MAX_ROWS) : SRW'(64);
  localparam logic [SCW-1:0] COLS_RST = (MAX_COLS < 64) ? SCW'(MAX_COLS) : SCW'(64);

  logic [IDX_W-1:0] in_row, in_col;
  logic [VAL_W-1:0] in_value;

  logic [SRW-1:0] grid_rows_q, kernel_rows_q, cfg_rows;
  logic [SCW-1:0] grid_cols_q, kernel_cols_q, cfg_cols;

  logic              kernel_we, grid_we;
  logic [RW+CW-1:0]  waddr, kernel_raddr, grid_raddr;
  logic [VAL_W-1:0]  kernel_rdata, grid_rdata;
  mac_ctrl_t         mac_ctrl;
  mac_stat_t         mac_stat;

  assign in_row   = s_axis_tdata[5:0];
  assign in_col   = s_axis_tdata[11:6];
  assign in_value = s_axis_tdata[43:12];

  // Size registers. A written zero means one; anything above the store
  // size means the store size.
  always_comb begin
    if (cfg_wdata_i == '0) begin
      cfg_rows = SRW'(1);
      cfg_cols = SCW'(1);
    end else begin
      cfg_rows = (int'(cfg_wdata_i) > MAX_ROWS) ? SRW'(MAX_ROWS) : SRW'(cfg_wdata_i);
      cfg_cols = (int'(cfg_wdata_i) > MAX_COLS) ? SCW'(MAX_COLS) : SCW'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q   <= ROWS_RST;
      grid_cols_q   <= COLS_RST;
      kernel_rows_q <= ROWS_RST;
      kernel_cols_q <= COLS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GRID_ROWS:   grid_rows_q   <= cfg_rows;
        REG_GRID_COLS:   grid_cols_q   <= cfg_cols;
        REG_KERNEL_ROWS: kernel_rows_q <= cfg_rows;
        REG_KERNEL_COLS: kernel_cols_q <= cfg_cols;
        default: ;
      endcase
    end
  end

  // Sequencer: item intake, index wrap and kernel walk
  cc2d_seq #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_seq (
    .clk_i,
    .rst_ni,
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .kind_i        (s_axis_tuser),
    .row_i         (in_row),
    .col_i         (in_col),
    .grid_rows_i   (grid_rows_q),
    .grid_cols_i   (grid_cols_q),
    .kernel_rows_i (kernel_rows_q),
    .kernel_cols_i (kernel_cols_q),
    .kernel_we_o   (kernel_we),
    .grid_we_o     (grid_we),
    .waddr_o       (waddr),
    .kernel_raddr_o(kernel_raddr),
    .grid_raddr_o  (grid_raddr),
    .ctrl_o        (mac_ctrl),
    .stat_i        (mac_stat)
  );

  // Stores, addressed {row, col}
  cc2d_ram #(
    .WIDTH(VAL_W),
    .DEPTH(DEPTH)
  ) u_kernel_ram (
    .clk_i,
    .we_i   (kernel_we),
    .waddr_i(waddr),
    .wdata_i(in_value),
    .raddr_i(kernel_raddr),
    .rdata_o(kernel_rdata)
  );

  cc2d_ram #(
    .WIDTH(VAL_W),
    .DEPTH(DEPTH)
  ) u_grid_ram (
    .clk_i,
    .we_i   (grid_we),
    .waddr_i(waddr),
    .wdata_i(in_value),
    .raddr_i(grid_raddr),
    .rdata_o(grid_rdata)
  );

  // Shared MAC, rounding, saturation and output register
  cc2d_mac u_mac (
    .clk_i,
    .rst_ni,
    .ctrl_i     (mac_ctrl),
    .stat_o     (mac_stat),
    .kernel_i   (kernel_rdata),
    .grid_i     (grid_rdata),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_sum_o  (m_axis_tdata),
    .out_sat_o  (m_axis_tuser)
  );

  // No products in flight once the block takes items again
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !mac_stat.busy)
    else $error("products in flight while ready");

  // A finished result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_ctrl.load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("pending result overwritten");

  // An accepted query holds off further items
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_QUERY) |=> !s_axis_tready)
    else $error("item taken during a query");

  // Store writes happen only on accepted items
  a_write_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kernel_we || grid_we) |-> (s_axis_tvalid && s_axis_tready && !(kernel_we && grid_we)))
    else $error("store write without an accepted item");

endmodule
